FILE: src/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Types and constants shared by the insertion sort engine and its cells.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned CAPACITY = 32;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               set_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               run_end;
    logic               overflowed;
  } out_item_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic               ins;
    logic               drain;
    logic               asc;
    logic signed [31:0] value;
  } ise_ctl_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic               shift;
    logic               stop;
  } ise_link_t;

endpackage

FILE: src/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Collects signed values into a sorted chain of cells and emits the sorted
// run when an item marked set_end arrives.
// ----------------------------------------------------------------------------
// While a set is being collected the block takes one item per cycle: every
// cell compares the new value at once and the chain shifts one place in the
// same cycle. An item with set_end starts the drain, which shifts the chain
// toward cell zero and gives one result per cycle while out_ready_i is high,
// with no input item taken until the last result has been taken. Items that
// arrive while all CAPACITY cells are full are dropped and overflowed is set
// on every result of that run. The user must write asc_q (reset 1) through
// cfg_we_i and cfg_data_i only while the block is idle; no check enforces it.
module insertion_sort_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ise_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ise_pkg::out_item_t out_item_o
);
  import ise_pkg::*;

  localparam ise_link_t HeadLink = '{value: '0, valid: 1'b1, shift: 1'b0, stop: 1'b0};
  localparam ise_link_t TailLink = '{value: '0, valid: 1'b0, shift: 1'b0, stop: 1'b0};

  logic                asc_q;
  logic                drain_q, drain_d;
  logic                drop_q, drop_d;
  logic                in_acc;
  logic                out_acc;
  logic                full;
  logic [CAPACITY-1:0] vld;
  ise_ctl_t            ctl;
  ise_link_t           links [CAPACITY];

  assign in_ready_o  = ~drain_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign full        = vld[CAPACITY-1];
  assign out_valid_o = drain_q;
  assign out_acc     = out_valid_o & out_ready_i;

  assign ctl.ins   = in_acc & ~full;
  assign ctl.drain = out_acc;
  assign ctl.asc   = asc_q;
  assign ctl.value = in_item_i.sample_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ise_link_t left, right;
    assign vld[i] = links[i].valid;
    if (i == 0) begin : g_head
      assign left = HeadLink;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = TailLink;
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    ise_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .left_i (left),
      .right_i(right),
      .link_o (links[i])
    );
  end

  assign out_item_o.sorted_value = links[0].value;
  assign out_item_o.run_end      = ~vld[1];
  assign out_item_o.overflowed   = drop_q;

  always_comb begin
    drain_d = drain_q;
    drop_d  = drop_q;
    if (in_acc && full) begin
      drop_d = 1'b1;
    end
    if (in_acc && in_item_i.set_end) begin
      drain_d = 1'b1;
    end
    if (out_acc && out_item_o.run_end) begin
      drain_d = 1'b0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q   <= 1'b1;
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        asc_q <= cfg_data_i;
      end
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld + 1'b1) & vld) == '0)
    else $error("occupied cells not contiguous from cell zero");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vld[0])
    else $error("draining with an empty chain");

  a_set_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.set_end |=> out_valid_o)
    else $error("set_end item did not start a drain");

  a_run_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.run_end |=> !out_valid_o && vld == '0 && !drop_q)
    else $error("chain not empty after run end");
`endif

endmodule

FILE: src/ise_cell.sv
// ----------------------------------------------------------------------------
// ise_cell
// One slot of the sorted chain: compares the broadcast value against its own
// entry, takes the left neighbor's entry or the new value on insert, and
// takes the right neighbor's entry on drain.
// ----------------------------------------------------------------------------
module ise_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ise_pkg::ise_ctl_t  ctl_i,
  input  ise_pkg::ise_link_t left_i,
  input  ise_pkg::ise_link_t right_i,
  output ise_pkg::ise_link_t link_o
);
  import ise_pkg::*;

  logic signed [31:0] value_q, value_d;
  logic               valid_q, valid_d;
  logic               prec;
  logic               stop;
  logic               moves;
  logic               take;

  assign prec  = ctl_i.asc ? (ctl_i.value < value_q) : (ctl_i.value > value_q);
  // An entry the new value does not precede pins itself and everything left of it
  assign stop  = valid_q & ~prec;
  assign moves = ~(stop | right_i.stop);
  assign link_o.value = value_q;
  assign link_o.valid = valid_q;
  assign link_o.shift = valid_q & moves;
  assign link_o.stop  = stop | right_i.stop;
  assign take = (valid_q | left_i.valid) & moves;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctl_i.drain) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end else if (ctl_i.ins && take) begin
      value_d = left_i.shift ? left_i.value : ctl_i.value;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
